>>> rtl/core/pfin_pkg.sv
// shared types, constants and the color distance function for the palette lookup
`default_nettype none

package pfin_pkg;

	// default table depth and fixed field widths
	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int COLOR_W             = 16;
	localparam int INDEX_W             = 8;
	localparam int KIND_W              = 2;
	localparam int DIST_W              = 13;

	// match kind codes on the result
	localparam logic [KIND_W-1:0] KIND_EXACT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEAR   = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic emit_exact;
		logic emit_insert;
		logic emit_near;
	} pfin_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic last_addr;
		logic cmp_valid;
		logic hit;
	} pfin_status_t;

	// byte swap of a stored color back to plain rgb565
	function automatic logic [COLOR_W-1:0] unswap(input logic [COLOR_W-1:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	// 2*dr^2 + dg^2 + 2*db^2 on plain rgb565 colors
	function automatic logic [DIST_W-1:0] weighted_distance(
		input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b
	);
		logic [4:0]  dr;
		logic [5:0]  dg;
		logic [4:0]  db;
		logic [9:0]  sr;
		logic [11:0] sg;
		logic [9:0]  sb;
		dr = (a[15:11] > b[15:11]) ? (a[15:11] - b[15:11]) : (b[15:11] - a[15:11]);
		dg = (a[10:5] > b[10:5]) ? (a[10:5] - b[10:5]) : (b[10:5] - a[10:5]);
		db = (a[4:0] > b[4:0]) ? (a[4:0] - b[4:0]) : (b[4:0] - a[4:0]);
		sr = 10'(dr) * 10'(dr);
		sg = 12'(dg) * 12'(dg);
		sb = 10'(db) * 10'(db);
		return DIST_W'({sr, 1'b0}) + DIST_W'(sg) + DIST_W'({sb, 1'b0});
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/pfin_ram.sv
// generic single write port ram with registered read
`default_nettype none

module pfin_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/pfin_ctrl.sv
// controller for the palette scan: sequences reads, picks the result kind
`default_nettype none

module pfin_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire pfin_pkg::pfin_status_t status,
	output pfin_pkg::pfin_cmd_t        cmd
);

	import pfin_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t state_q;
	logic   issued_all_q;
	logic   scan_end;

	assign busy     = (state_q != ST_IDLE);
	assign scan_end = issued_all_q && !status.cmp_valid;

	// command decode
	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == ST_IDLE) && start;
		cmd.issue       = (state_q == ST_SCAN) && !issued_all_q && !status.hit;
		cmd.emit_exact  = (state_q == ST_SCAN) && status.hit;
		cmd.emit_insert = (state_q == ST_SCAN) && !status.hit && scan_end && !status.full;
		cmd.emit_near   = (state_q == ST_SCAN) && !status.hit && scan_end && status.full;
	end

	// state and issue tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issued_all_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q      <= ST_SCAN;
						issued_all_q <= status.empty;
					end
				end
				ST_SCAN: begin
					if (cmd.issue && status.last_addr) begin
						issued_all_q <= 1'b1;
					end
					if (cmd.emit_exact || cmd.emit_insert || cmd.emit_near) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// at most one result per item
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_exact, cmd.emit_insert, cmd.emit_near}))
		else $error("more than one result kind in a cycle");

	// no reads issued once the scan has covered every entry
	a_no_late_issue: assert property (@(posedge clk) disable iff (!arst_n)
		issued_all_q && state_q == ST_SCAN |-> !cmd.issue)
		else $error("read issued past the last entry");

	// a request is only taken while idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> $past(state_q) == ST_IDLE && state_q == ST_SCAN)
		else $error("request taken outside idle");

endmodule

`default_nettype wire

>>> rtl/core/pfin_dp.sv
// datapath: palette ram, fill count, exact compare, nearest tracking, result register
`default_nettype none

module pfin_dp #(
	parameter int PALETTE_ENTRIES = pfin_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pfin_pkg::pfin_cmd_t           cmd,
	output pfin_pkg::pfin_status_t             status,
	input  wire logic [pfin_pkg::COLOR_W-1:0]  color_in,
	output logic                               valid,
	output logic      [pfin_pkg::INDEX_W-1:0]  palette_index,
	output logic      [pfin_pkg::KIND_W-1:0]   match_kind
);

	import pfin_pkg::*;

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

	logic [COLOR_W-1:0] color_q;
	logic [COLOR_W-1:0] key_q;
	logic [IDX_W-1:0]   addr_q;
	logic [CNT_W-1:0]   count_q;
	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [DIST_W-1:0]  best_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [COLOR_W-1:0] rdata;
	logic [DIST_W-1:0]  entry_dist;
	logic [IDX_W-1:0]   scan_top_idx;
	logic               valid_q;
	logic [INDEX_W-1:0] index_q;
	logic [KIND_W-1:0]  kind_q;

	// palette storage, entries past the fill count are never used
	pfin_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.emit_insert),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (color_q),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// status toward the controller
	assign scan_top_idx     = IDX_W'(count_q - CNT_W'(1));
	assign entry_dist       = weighted_distance(unswap(rdata), key_q);
	assign status.empty     = (count_q == CNT_W'(1));
	assign status.full      = (count_q == CNT_W'(PALETTE_ENTRIES));
	assign status.last_addr = (addr_q == scan_top_idx);
	assign status.cmp_valid = valid_s1;
	assign status.hit       = valid_s1 && (rdata == color_q);

	// request capture and scan address
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			color_q <= color_in;
			key_q   <= unswap(color_in);
			addr_q  <= IDX_W'(1);
		end else if (cmd.issue) begin
			addr_q <= addr_q + IDX_W'(1);
		end
		idx_s1 <= addr_q;
	end

	// read data valid flag, set in the cycle after an issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
		end
	end

	// nearest entry so far, first entry wins a tie
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			best_q <= '1;
		end else if (valid_s1 && entry_dist < best_q) begin
			best_q     <= entry_dist;
			best_idx_q <= idx_s1;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
		end else if (cmd.emit_insert) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// result register, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit_exact || cmd.emit_insert || cmd.emit_near;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_exact) begin
			index_q <= INDEX_W'(idx_s1);
			kind_q  <= KIND_EXACT;
		end else if (cmd.emit_insert) begin
			index_q <= INDEX_W'(count_q);
			kind_q  <= KIND_INSERT;
		end else if (cmd.emit_near) begin
			index_q <= INDEX_W'(best_idx_q);
			kind_q  <= KIND_NEAR;
		end
	end

	assign valid         = valid_q;
	assign palette_index = index_q;
	assign match_kind    = kind_q;

	// fill count stays in range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CNT_W'(PALETTE_ENTRIES))
		else $error("fill count out of range");

	// no append into a full table
	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_insert |-> !status.full)
		else $error("append into full table");

	// a shown result never carries the unused kind code
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> kind_q == KIND_EXACT || kind_q == KIND_INSERT || kind_q == KIND_NEAR)
		else $error("illegal match kind");

endmodule

`default_nettype wire

>>> rtl/core/palette_find_insert_nearest_top.sv
// top level of the palette lookup with append and nearest-color fallback
//
// Usage: drive color_in (byte-swapped rgb565) and raise start; the request is
// taken at a rising edge where start is high and busy is low. busy stays high
// while the palette is scanned. Exactly one result follows each request:
// valid is high for one cycle with palette_index and match_kind (0 exact
// match, 1 appended, 2 nearest entry). The receiver cannot stall the block;
// a result must be taken in the cycle that valid is high.
// Scan: the table is read one entry per cycle from a ram with one write port
// and a registered read port, entries 1 to used-1. With an empty table no
// entry is read; otherwise the scan stops early on an exact match. The next
// request can be taken in the cycle valid is shown.
// A full table does the exact and nearest search in the same single pass.
// Reset (arst_n low) empties the table to a fill count of one; no ram
// clearing pass is needed since entries past the fill count are never used.
`default_nettype none

module palette_find_insert_nearest_top #(
	parameter int PALETTE_ENTRIES = pfin_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [pfin_pkg::COLOR_W-1:0]  color_in,
	output logic                               valid,
	output logic      [pfin_pkg::INDEX_W-1:0]  palette_index,
	output logic      [pfin_pkg::KIND_W-1:0]   match_kind
);

	import pfin_pkg::*;

	pfin_cmd_t    cmd;
	pfin_status_t status;

	// sequencing
	pfin_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	// table, compare and result
	pfin_dp #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.color_in      (color_in),
		.valid         (valid),
		.palette_index (palette_index),
		.match_kind    (match_kind)
	);

endmodule

`default_nettype wire

>>> test/tb_palette_find_insert_nearest_top.sv
// testbench for the palette lookup: predicted index and match kind checked per request
`timescale 1ns / 100ps

module tb_palette_find_insert_nearest_top;

	import pfin_pkg::*;

	localparam int PALETTE_ENTRIES = 256;
	localparam int ITEM_TARGET     = 1050;
	localparam int IDLE_LIMIT      = 4 * (PALETTE_ENTRIES + 1 + 12 + 8);

	// one pending request; drain holds it back until every result is in
	typedef struct {
		logic [COLOR_W-1:0] color;
		bit                 drain;
	} color_req_t;

	// one predicted result
	typedef struct {
		logic [INDEX_W-1:0] index;
		logic [KIND_W-1:0]  kind;
	} lookup_res_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                start    = 1'b0;
	logic [COLOR_W-1:0]  color_in = '0;
	logic                busy;
	logic                valid;
	logic [INDEX_W-1:0]  palette_index;
	logic [KIND_W-1:0]   match_kind;

	color_req_t          color_queue[$];
	lookup_res_t         lookup_expected[$];
	color_req_t          drv_req;
	lookup_res_t         mon_exp;
	int                  gap_left   = 0;
	bit                  burst      = 1'b0;
	int                  n_sent     = 0;
	int                  n_recv     = 0;
	int                  fail_count = 0;
	int                  idle_cycles = 0;

	// predictor state: shadow color table and fill count
	logic [COLOR_W-1:0]  pal_shadow [PALETTE_ENTRIES];
	int                  fill_count = 1;

	// stimulus bookkeeping: colors known to sit in the table
	bit                  known_set [logic [COLOR_W-1:0]];
	logic [COLOR_W-1:0]  known_list[$];

	palette_find_insert_nearest_top #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.color_in     (color_in),
		.valid        (valid),
		.palette_index(palette_index),
		.match_kind   (match_kind)
	);

	always #6 clk = ~clk;

	// exact search, then append, then nearest weighted distance on a full table
	function automatic lookup_res_t predict_lookup(input logic [COLOR_W-1:0] c);
		lookup_res_t        r;
		logic [COLOR_W-1:0] key;
		logic [COLOR_W-1:0] ent;
		int                 i;
		int                 best_i;
		int                 best_d;
		int                 d;
		int                 dr;
		int                 dg;
		int                 db;
		for (i = 1; i < fill_count; i++) begin
			if (pal_shadow[i] == c) begin
				r.index = INDEX_W'(i);
				r.kind  = KIND_EXACT;
				return r;
			end
		end
		if (fill_count < PALETTE_ENTRIES) begin
			pal_shadow[fill_count] = c;
			r.index = INDEX_W'(fill_count);
			r.kind  = KIND_INSERT;
			fill_count++;
			return r;
		end
		key    = {c[7:0], c[15:8]};
		best_i = 1;
		best_d = 1 << 30;
		for (i = 1; i < PALETTE_ENTRIES; i++) begin
			ent = {pal_shadow[i][7:0], pal_shadow[i][15:8]};
			dr  = int'(ent[15:11]) - int'(key[15:11]);
			dg  = int'(ent[10:5]) - int'(key[10:5]);
			db  = int'(ent[4:0]) - int'(key[4:0]);
			d   = 2 * dr * dr + dg * dg + 2 * db * db;
			if (d < best_d) begin
				best_d = d;
				best_i = i;
			end
		end
		r.index = INDEX_W'(best_i);
		r.kind  = KIND_NEAR;
		return r;
	endfunction

	// append a request and track which colors the table will hold
	task automatic queue_color(input logic [COLOR_W-1:0] c, input bit drain);
		color_req_t req;
		req.color = c;
		req.drain = drain;
		color_queue.push_back(req);
		if (known_list.size() < PALETTE_ENTRIES - 1 && !known_set.exists(c)) begin
			known_set[c] = 1'b1;
			known_list.push_back(c);
		end
	endtask

	// driver: hold a request until taken, then wait a drawn gap before the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			color_in <= '0;
		end else if (!(start && busy)) begin
			if (start) begin
				lookup_expected.push_back(predict_lookup(color_in));
				n_sent   <= n_sent + 1;
				gap_left = burst ? 0 : $urandom_range(0, 12);
				if (n_sent % 64 == 63)
					burst = $urandom_range(0, 1);
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (color_queue.size() > 0 && (!color_queue[0].drain ||
			             (!start && !busy && n_recv == n_sent))) begin
				drv_req  = color_queue.pop_front();
				color_in <= drv_req.color;
				start    <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every strobed result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (lookup_expected.size() == 0) begin
				$error("unexpected result: palette_index %0d match_kind %0d",
				       palette_index, match_kind);
				fail_count++;
			end else begin
				mon_exp = lookup_expected.pop_front();
				if (palette_index !== mon_exp.index) begin
					$error("palette_index: expected %0d, actual %0d",
					       mon_exp.index, palette_index);
					fail_count++;
				end
				if (match_kind !== mon_exp.kind) begin
					$error("match_kind: expected %0d, actual %0d",
					       mon_exp.kind, match_kind);
					fail_count++;
				end
			end
			n_recv <= n_recv + 1;
		end
	end

	// watchdog on cycles with neither a request nor a result taken
	always @(posedge clk) begin
		if ((start && !busy) || valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[palette_find_insert_nearest_top] ERROR");
			$finish;
		end
	end

	// stimulus build, reset, end of run
	initial begin
		logic [COLOR_W-1:0] c;
		int                 total;
		int                 sel;
		int                 idx;

		// directed: black, channel extremes, repeats, single bits
		queue_color(16'h0000, 1'b0);
		queue_color(16'h0000, 1'b0);
		queue_color(16'hFFFF, 1'b0);
		queue_color(16'hFFFF, 1'b0);
		queue_color(16'h00F8, 1'b0);
		queue_color(16'hE007, 1'b0);
		queue_color(16'h1F00, 1'b0);
		queue_color(16'h00F8, 1'b0);
		queue_color(16'h0100, 1'b0);
		queue_color(16'h0080, 1'b0);
		queue_color(16'h8000, 1'b0);
		queue_color(16'h0001, 1'b0);
		queue_color(16'hFF00, 1'b0);
		queue_color(16'h00FF, 1'b0);
		queue_color(16'hFFFF, 1'b0);
		total = color_queue.size();

		// fill phase: new distinct colors mixed with repeats
		sel = 0;
		while (known_list.size() < PALETTE_ENTRIES - 1) begin
			if ($urandom_range(0, 9) < 3) begin
				c = known_list[$urandom_range(0, known_list.size() - 1)];
			end else begin
				c = 16'($urandom);
				while (known_set.exists(c))
					c = 16'($urandom);
			end
			queue_color(c, sel == 0);
			sel++;
			total++;
		end

		// full table: exact hits, near misses and random colors
		sel = 0;
		while (total < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					case ($urandom_range(0, 5))
						0:       idx = 0;
						1:       idx = known_list.size() - 1;
						default: idx = $urandom_range(0, known_list.size() - 1);
					endcase
					c = known_list[idx];
				end
				4, 5: begin
					c = known_list[$urandom_range(0, known_list.size() - 1)];
					c = c ^ (16'h1 << $urandom_range(0, 15));
					if ($urandom_range(0, 1))
						c = c ^ (16'h1 << $urandom_range(0, 15));
				end
				default: c = 16'($urandom);
			endcase
			queue_color(c, sel % 250 == 0);
			sel++;
			total++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all requests taken and all results in
		@(posedge clk);
		while (color_queue.size() > 0 || start || n_recv != n_sent)
			@(posedge clk);
		repeat (PALETTE_ENTRIES + 8) @(posedge clk);

		if (fail_count == 0 && lookup_expected.size() == 0)
			$display("[palette_find_insert_nearest_top] OK");
		else
			$display("[palette_find_insert_nearest_top] ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/pfin_pkg.sv
rtl/core/pfin_ram.sv
rtl/core/pfin_ctrl.sv
rtl/core/pfin_dp.sv
rtl/core/palette_find_insert_nearest_top.sv
test/tb_palette_find_insert_nearest_top.sv
